[hw/rtl/ts_metadata_descriptor_parser_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the metadata descriptor parser
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TS_METADATA_DESCRIPTOR_PARSER_ASSERT_SVH
`define TS_METADATA_DESCRIPTOR_PARSER_ASSERT_SVH

// Same-cycle implication
`define TSMDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TSMDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tsmdp_pkg.sv]
// ---------------------------------------------------------------------------
// tsmdp_pkg
// Types and constants for the transport stream metadata descriptor parser.
// ---------------------------------------------------------------------------
`default_nettype none

package tsmdp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 32;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_APP_FMT  = 4'd1,
        PH_APP_ID   = 4'd2,
        PH_FMT      = 4'd3,
        PH_FMT_ID   = 4'd4,
        PH_SVC_ID   = 4'd5,
        PH_FLAGS    = 4'd6,
        PH_REC_LEN  = 4'd7,
        PH_REC_BYTE = 4'd8,
        PH_CFG_LEN  = 4'd9,
        PH_CFG_BYTE = 4'd10,
        PH_CID_LEN  = 4'd11,
        PH_CID_BYTE = 4'd12,
        PH_CFG_SVC  = 4'd13
    } phase_t;

    localparam logic [3:0] KIND_APP_FMT     = 4'd0;
    localparam logic [3:0] KIND_APP_ID      = 4'd1;
    localparam logic [3:0] KIND_FMT         = 4'd2;
    localparam logic [3:0] KIND_FMT_ID      = 4'd3;
    localparam logic [3:0] KIND_SVC_ID      = 4'd4;
    localparam logic [3:0] KIND_FLAGS       = 4'd5;
    localparam logic [3:0] KIND_REC_LEN     = 4'd6;
    localparam logic [3:0] KIND_REC_BYTE    = 4'd7;
    localparam logic [3:0] KIND_CFG_LEN     = 4'd8;
    localparam logic [3:0] KIND_CFG_BYTE    = 4'd9;
    localparam logic [3:0] KIND_CID_LEN     = 4'd10;
    localparam logic [3:0] KIND_CID_BYTE    = 4'd11;
    localparam logic [3:0] KIND_CFG_SVC_ID  = 4'd12;

    localparam logic [15:0] APP_FMT_ESCAPE = 16'hFFFF;
    localparam logic [7:0]  FMT_ESCAPE     = 8'hFF;

    localparam logic [2:0] CFG_DECODER    = 3'd1;
    localparam logic [2:0] CFG_DECODER_ID = 3'd3;
    localparam logic [2:0] CFG_SERVICE_ID = 3'd4;

    // Section that follows the service id record, chosen by the config flags
    function automatic phase_t after_record(input logic [2:0] cfg);
        phase_t ph;
        unique case (cfg)
            CFG_DECODER:    ph = PH_CFG_LEN;
            CFG_DECODER_ID: ph = PH_CID_LEN;
            CFG_SERVICE_ID: ph = PH_CFG_SVC;
            default:        ph = PH_IDLE;
        endcase
        return ph;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ts_metadata_descriptor_parser.sv]
// A result word is registered and appears on the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle while s_tready is high; each byte updates the parse state and the
// result register in a single pass.
// s_tready drops only while a finished result waits on a stalled master side.
// Reset (rst_n low, asynchronous) returns the parser to idle and empties the result register.
// ---------------------------------------------------------------------------
// ts_metadata_descriptor_parser
// Byte-serial parser for a transport stream metadata descriptor body; emits
// one word per completed field.
// ---------------------------------------------------------------------------
`default_nettype none

module ts_metadata_descriptor_parser
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tsmdp_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  wire logic                           s_tuser,   // [0] start_of_descriptor
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tsmdp_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [3:0] field_kind, [35:4] field_value
    output logic                                m_tlast,   // last_of_descriptor
    output logic                                m_tuser    // [0] interrupted
);

    import tsmdp_pkg::*;

    `include "ts_metadata_descriptor_parser_assert.svh"

    phase_t       phase_reg, phase_next;
    logic [1:0]   byte_count_reg, byte_count_next;
    logic [31:0]  acc_reg, acc_next;
    logic [7:0]   remaining_reg, remaining_next;
    logic [2:0]   cfg_flags_reg, cfg_flags_next;
    logic         dsmcc_reg, dsmcc_next;
    logic         pending_int_reg, pending_int_next;

    logic         out_valid_reg;
    logic [3:0]   out_kind_reg;
    logic [31:0]  out_value_reg;
    logic         out_last_reg;
    logic         out_int_reg;

    logic         s_acc;
    logic         emit;
    logic [3:0]   emit_kind;
    logic [31:0]  emit_value;
    logic         emit_last;
    logic [15:0]  fmt16;
    logic [31:0]  word32;
    logic [7:0]   rem_dec;
    phase_t       ph_tmp;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    assign fmt16   = {acc_reg[7:0], s_tdata};
    assign word32  = {acc_reg[23:0], s_tdata};
    assign rem_dec = (remaining_reg != 8'd0) ? (remaining_reg - 8'd1) : remaining_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        acc_next         = acc_reg;
        remaining_next   = remaining_reg;
        cfg_flags_next   = cfg_flags_reg;
        dsmcc_next       = dsmcc_reg;
        pending_int_next = pending_int_reg;
        emit             = 1'b0;
        emit_kind        = KIND_APP_FMT;
        emit_value       = {24'd0, s_tdata};
        emit_last        = 1'b0;
        ph_tmp           = PH_IDLE;

        if (s_tuser)
        begin
            // restart: abandon whatever was in flight
            pending_int_next = (phase_reg != PH_IDLE);
            phase_next       = PH_APP_FMT;
            acc_next         = {24'd0, s_tdata};
            byte_count_next  = 2'd1;
            remaining_next   = 8'd0;
            cfg_flags_next   = 3'd0;
            dsmcc_next       = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_APP_FMT:
                begin
                    emit            = 1'b1;
                    emit_kind       = KIND_APP_FMT;
                    emit_value      = {16'd0, fmt16};
                    phase_next      = (fmt16 == APP_FMT_ESCAPE) ? PH_APP_ID : PH_FMT;
                    byte_count_next = 2'd0;
                    acc_next        = 32'd0;
                end
                PH_APP_ID, PH_FMT_ID:
                begin
                    if (byte_count_reg != 2'd3)
                    begin
                        acc_next        = word32;
                        byte_count_next = byte_count_reg + 2'd1;
                    end
                    else
                    begin
                        emit            = 1'b1;
                        emit_kind       = (phase_reg == PH_APP_ID) ? KIND_APP_ID : KIND_FMT_ID;
                        emit_value      = word32;
                        phase_next      = (phase_reg == PH_APP_ID) ? PH_FMT : PH_SVC_ID;
                        byte_count_next = 2'd0;
                        acc_next        = 32'd0;
                    end
                end
                PH_FMT:
                begin
                    emit            = 1'b1;
                    emit_kind       = KIND_FMT;
                    phase_next      = (s_tdata == FMT_ESCAPE) ? PH_FMT_ID : PH_SVC_ID;
                    byte_count_next = 2'd0;
                    acc_next        = 32'd0;
                end
                PH_SVC_ID:
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_SVC_ID;
                    phase_next = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    // keep the config flags and dsmcc bit, drop the reserved nibble
                    cfg_flags_next = s_tdata[7:5];
                    dsmcc_next     = s_tdata[4];
                    ph_tmp         = s_tdata[4] ? PH_REC_LEN : after_record(s_tdata[7:5]);
                    emit           = 1'b1;
                    emit_kind      = KIND_FLAGS;
                    emit_value     = {28'd0, s_tdata[7:4]};
                    emit_last      = (ph_tmp == PH_IDLE);
                    phase_next     = ph_tmp;
                end
                PH_REC_LEN, PH_CFG_LEN, PH_CID_LEN:
                begin
                    remaining_next = s_tdata;
                    unique case (phase_reg)
                        PH_REC_LEN:
                        begin
                            emit_kind = KIND_REC_LEN;
                            ph_tmp    = (s_tdata != 8'd0) ? PH_REC_BYTE
                                                          : after_record(cfg_flags_reg);
                        end
                        PH_CFG_LEN:
                        begin
                            emit_kind = KIND_CFG_LEN;
                            ph_tmp    = (s_tdata != 8'd0) ? PH_CFG_BYTE : PH_IDLE;
                        end
                        default:
                        begin
                            emit_kind = KIND_CID_LEN;
                            ph_tmp    = (s_tdata != 8'd0) ? PH_CID_BYTE : PH_IDLE;
                        end
                    endcase
                    emit       = 1'b1;
                    emit_last  = (ph_tmp == PH_IDLE);
                    phase_next = ph_tmp;
                end
                PH_REC_BYTE, PH_CFG_BYTE, PH_CID_BYTE:
                begin
                    remaining_next = rem_dec;
                    ph_tmp         = phase_reg;
                    if (rem_dec == 8'd0)
                    begin
                        ph_tmp = (phase_reg == PH_REC_BYTE) ? after_record(cfg_flags_reg)
                                                            : PH_IDLE;
                    end
                    unique case (phase_reg)
                        PH_REC_BYTE: emit_kind = KIND_REC_BYTE;
                        PH_CFG_BYTE: emit_kind = KIND_CFG_BYTE;
                        default:     emit_kind = KIND_CID_BYTE;
                    endcase
                    emit       = 1'b1;
                    emit_last  = (ph_tmp == PH_IDLE);
                    phase_next = ph_tmp;
                end
                PH_CFG_SVC:
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_CFG_SVC_ID;
                    emit_last  = 1'b1;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    // idle or unused code: drop the byte
                    phase_next = PH_IDLE;
                end
            endcase
            if (emit)
            begin
                pending_int_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_count_reg  <= 2'd0;
            acc_reg         <= 32'd0;
            remaining_reg   <= 8'd0;
            cfg_flags_reg   <= 3'd0;
            dsmcc_reg       <= 1'b0;
            pending_int_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_acc)
            begin
                phase_reg       <= phase_next;
                byte_count_reg  <= byte_count_next;
                acc_reg         <= acc_next;
                remaining_reg   <= remaining_next;
                cfg_flags_reg   <= cfg_flags_next;
                dsmcc_reg       <= dsmcc_next;
                pending_int_reg <= pending_int_next;
                out_valid_reg   <= emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load with each emitting byte
    always_ff @(posedge clk)
    begin
        if (s_acc && emit)
        begin
            out_kind_reg  <= emit_kind;
            out_value_reg <= emit_value;
            out_last_reg  <= emit_last;
            out_int_reg   <= pending_int_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_value_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_int_reg;

    `TSMDP_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
        "byte taken while result stalled")
    `TSMDP_ASSERT_NEXT(a_start_enters_fmt, s_acc && s_tuser, phase_reg == PH_APP_FMT,
        "start byte did not open a descriptor")
    `TSMDP_ASSERT_NOW(a_last_means_idle, m_tvalid && m_tlast, phase_reg == PH_IDLE,
        "last field emitted but parse still open")
    `TSMDP_ASSERT_NOW(a_kind_range, m_tvalid, m_tdata[3:0] <= KIND_CFG_SVC_ID,
        "field kind out of range")

endmodule

`default_nettype wire
